// ===== src/dsrq_pkg.sv =====
// Shared types and constants of the depth sorted render queue.
// Holds the action codes, fixed field widths and the controller/datapath structs.
package dsrq_pkg;

    // Fixed widths of the word fields
    localparam int HANDLE_W = 16;
    localparam int DEPTH_W  = 32;

    // Action codes of an input word
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DRAIN  = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;
    localparam logic [1:0] ACT_NOP    = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ins;    // insert the input item into its list
        logic clr;    // empty both lists
        logic ack;    // emit a result word that carries no entry
        logic rd;     // emit the entry at the read index
        logic sel_t;  // read from the transparent list
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic o_empty;  // opaque list holds no entry
        logic t_empty;  // transparent list holds no entry
        logic end_o;    // read index is at the last opaque entry
        logic end_t;    // read index is at the last transparent entry
    } t_stat;

endpackage

// ===== src/depth_sorted_render_queue.sv =====
// Depth sorted render queue: an insert, drain or clear word is taken at a clock edge with
// start high and busy low. Insert and clear can follow back to back; their single result
// word (o_strobe, o_last high) appears in the cycle after the accept. A drain of a
// non-empty queue raises busy and then emits one word per cycle, opaque entries first,
// nearest first, then transparent entries, farthest first, with o_last on the final one,
// paced by the single read index walking the lists; an empty drain gives one word in the
// next cycle. Results cannot be held off and must be taken when o_strobe
// is high. Each list holds LIST_DEPTH entries; an insert into a full list is dropped and
// its result carries o_status high.
// Depends on dsrq_pkg, dsrq_ctrl and dsrq_dp.
module depth_sorted_render_queue #(
    parameter int LIST_DEPTH  = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_action,
    input  logic [dsrq_pkg::HANDLE_W-1:0]       i_item_handle,
    input  logic signed [dsrq_pkg::DEPTH_W-1:0] i_depth,
    input  logic                                i_is_transparent,
    input  logic                                i_use_effect,
    output logic                                o_strobe,
    output logic [dsrq_pkg::HANDLE_W-1:0]       o_out_handle,
    output logic signed [dsrq_pkg::DEPTH_W-1:0] o_out_depth,
    output logic                                o_out_effect,
    output logic                                o_out_transparent,
    output logic                                o_entry_valid,
    output logic                                o_last,
    output logic                                o_status
);
    import dsrq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dsrq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    dsrq_dp #(
        .LIST_DEPTH  (LIST_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_item_handle     (i_item_handle),
        .i_depth           (i_depth),
        .i_is_transparent  (i_is_transparent),
        .i_use_effect      (i_use_effect),
        .o_strobe          (o_strobe),
        .o_out_handle      (o_out_handle),
        .o_out_depth       (o_out_depth),
        .o_out_effect      (o_out_effect),
        .o_out_transparent (o_out_transparent),
        .o_entry_valid     (o_entry_valid),
        .o_last            (o_last),
        .o_status          (o_status)
    );

    // An accepted insert answers with one closing word in the next cycle
    a_insert_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == ACT_INSERT) |=> (o_strobe && o_last && !o_entry_valid))
        else $error("insert did not answer in the next cycle");

    // A word without an entry always closes its command
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_entry_valid) |-> o_last)
        else $error("entry-less word without last");

    // A dropped insert is flagged only on an entry-less word
    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status |-> (o_strobe && !o_entry_valid))
        else $error("status set on a drained entry");

    // Busy ends only with the final drained word
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (o_strobe && o_last))
        else $error("drain ended without its last word");

endmodule

// ===== src/dsrq_ctrl.sv =====
// Controller of the depth sorted render queue: accepts commands and sequences drains.
// Depends on dsrq_pkg for the action codes and the command/status structs.
module dsrq_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic [1:0]           i_action,
    input  dsrq_pkg::t_stat      i_stat,
    output dsrq_pkg::t_cmd       o_cmd,
    output logic                 busy
);
    import dsrq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_DRAIN_O = 3'b010,
        S_DRAIN_T = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);

    // Decode the command word and walk the lists during a drain
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_INSERT: begin
                            o_cmd.ins = 1'b1;
                            o_cmd.ack = 1'b1;
                        end
                        ACT_DRAIN: begin
                            if (i_stat.o_empty && i_stat.t_empty) begin
                                o_cmd.ack = 1'b1;
                            end else if (!i_stat.o_empty) begin
                                n_state = S_DRAIN_O;
                            end else begin
                                n_state = S_DRAIN_T;
                            end
                        end
                        ACT_CLEAR: begin
                            o_cmd.clr = 1'b1;
                            o_cmd.ack = 1'b1;
                        end
                        ACT_NOP: begin
                            o_cmd = '0;
                        end
                        default: begin
                            o_cmd = '0;
                        end
                    endcase
                end
            end
            S_DRAIN_O: begin
                o_cmd.rd    = 1'b1;
                o_cmd.sel_t = 1'b0;
                if (i_stat.end_o) begin
                    n_state = i_stat.t_empty ? S_IDLE : S_DRAIN_T;
                end
            end
            S_DRAIN_T: begin
                o_cmd.rd    = 1'b1;
                o_cmd.sel_t = 1'b1;
                if (i_stat.end_t) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/dsrq_dp.sv =====
// Datapath of the depth sorted render queue: two shifting sorted lists,
// the drain read index and the result word register. Depends on dsrq_pkg.
module dsrq_dp #(
    parameter int LIST_DEPTH  = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dsrq_pkg::t_cmd                 i_cmd,
    output dsrq_pkg::t_stat                o_stat,
    input  logic [dsrq_pkg::HANDLE_W-1:0]  i_item_handle,
    input  logic signed [dsrq_pkg::DEPTH_W-1:0] i_depth,
    input  logic                           i_is_transparent,
    input  logic                           i_use_effect,
    output logic                           o_strobe,
    output logic [dsrq_pkg::HANDLE_W-1:0]  o_out_handle,
    output logic signed [dsrq_pkg::DEPTH_W-1:0] o_out_depth,
    output logic                           o_out_effect,
    output logic                           o_out_transparent,
    output logic                           o_entry_valid,
    output logic                           o_last,
    output logic                           o_status
);
    import dsrq_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = $clog2(LIST_DEPTH);
    localparam int HB = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    // List storage: index 0 opaque (nearest first), 1 transparent (farthest first)
    logic [HB-1:0]      r_hnd [2][LIST_DEPTH];
    logic [HB-1:0]      n_hnd [2][LIST_DEPTH];
    logic [DEPTH_W-1:0] r_dep [2][LIST_DEPTH];
    logic [DEPTH_W-1:0] n_dep [2][LIST_DEPTH];
    logic               r_eff [2][LIST_DEPTH];
    logic               n_eff [2][LIST_DEPTH];
    logic [CW-1:0]      r_cnt [2];
    logic [CW-1:0]      n_cnt [2];
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      n_idx;

    // Result word register
    logic               r_strobe, n_strobe;
    logic [HB-1:0]      r_handle, n_handle;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_effect, n_effect;
    logic               r_transp, n_transp;
    logic               r_valid, n_valid;
    logic               r_last, n_last;
    logic               r_status, n_status;

    logic                tl;
    logic                full;
    logic [LIST_DEPTH-1:0] b;
    logic [CW-1:0]       idx_ext;
    logic                end_o;
    logic                end_t;
    logic                end_sel;

    // Status of the lists and the read index
    always_comb begin
        idx_ext        = CW'(r_idx);
        end_o          = ((idx_ext + CW'(1)) == r_cnt[0]);
        end_t          = ((idx_ext + CW'(1)) == r_cnt[1]);
        o_stat.o_empty = (r_cnt[0] == '0);
        o_stat.t_empty = (r_cnt[1] == '0);
        o_stat.end_o   = end_o;
        o_stat.end_t   = end_t;
    end

    // Compare the new depth against every entry and shift it into place
    always_comb begin
        tl    = i_is_transparent;
        full  = (r_cnt[tl] == CW'(LIST_DEPTH));
        n_hnd = r_hnd;
        n_dep = r_dep;
        n_eff = r_eff;
        n_cnt = r_cnt;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            b[i] = (CW'(i) < r_cnt[tl]) &&
                   (tl ? (i_depth > $signed(r_dep[1][i]))
                       : (i_depth < $signed(r_dep[0][i])));
        end
        if (i_cmd.ins && !full) begin
            for (int i = 0; i < LIST_DEPTH; i++) begin
                if (i > 0 && b[(i > 0) ? i - 1 : 0]) begin
                    n_hnd[tl][i] = r_hnd[tl][(i > 0) ? i - 1 : 0];
                    n_dep[tl][i] = r_dep[tl][(i > 0) ? i - 1 : 0];
                    n_eff[tl][i] = r_eff[tl][(i > 0) ? i - 1 : 0];
                end else if (b[i] || (CW'(i) == r_cnt[tl])) begin
                    n_hnd[tl][i] = i_item_handle[HB-1:0];
                    n_dep[tl][i] = i_depth;
                    n_eff[tl][i] = i_use_effect;
                end
            end
            n_cnt[tl] = r_cnt[tl] + CW'(1);
        end
        if (i_cmd.clr) begin
            n_cnt[0] = '0;
            n_cnt[1] = '0;
        end
    end

    // Step the read index; wrap to zero at the end of each list
    always_comb begin
        end_sel = i_cmd.sel_t ? end_t : end_o;
        n_idx   = r_idx;
        if (i_cmd.rd) begin
            n_idx = end_sel ? '0 : (r_idx + IW'(1));
        end
    end

    // Build the next result word
    always_comb begin
        n_strobe = i_cmd.ack || i_cmd.rd;
        n_handle = '0;
        n_depth  = '0;
        n_effect = 1'b0;
        n_transp = 1'b0;
        n_valid  = 1'b0;
        n_last   = 1'b1;
        n_status = i_cmd.ins && full;
        if (i_cmd.rd) begin
            n_handle = r_hnd[i_cmd.sel_t][r_idx];
            n_depth  = r_dep[i_cmd.sel_t][r_idx];
            n_effect = r_eff[i_cmd.sel_t][r_idx];
            n_transp = i_cmd.sel_t;
            n_valid  = 1'b1;
            n_last   = i_cmd.sel_t ? end_t : (end_o && o_stat.t_empty);
            n_status = 1'b0;
        end
    end

    // Hold list payload and result payload
    always_ff @(posedge i_clk) begin
        r_hnd    <= n_hnd;
        r_dep    <= n_dep;
        r_eff    <= n_eff;
        r_handle <= n_handle;
        r_depth  <= n_depth;
        r_effect <= n_effect;
        r_transp <= n_transp;
        r_valid  <= n_valid;
        r_last   <= n_last;
        r_status <= n_status;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    assign o_strobe          = r_strobe;
    assign o_out_handle      = HANDLE_W'(r_handle);
    assign o_out_depth       = r_depth;
    assign o_out_effect      = r_effect;
    assign o_out_transparent = r_transp;
    assign o_entry_valid     = r_valid;
    assign o_last            = r_last;
    assign o_status          = r_status;

endmodule
